// File: design/rspe_pkg.sv
// Shared types, constants and GF(256) helpers for the Reed-Solomon parity encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package rspe_pkg;

    localparam int MAX_PARITY = 64;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 7;                    // holds a parity count up to MAX_PARITY
    localparam int IDX_W      = $clog2(MAX_PARITY);   // position within the register

    localparam logic [CNT_W-1:0]  RESET_PARITY = 7'd16;
    localparam logic [CNT_W-1:0]  MIN_PARITY   = 7'd2;
    localparam logic [CNT_W-1:0]  TOP_PARITY   = CNT_W'(MAX_PARITY);
    // Field polynomial x^8+x^4+x^3+x^2+1, low eight bits
    localparam logic [BYTE_W-1:0] FIELD_POLY   = 8'h1d;
    localparam logic [BYTE_W-1:0] GF_ONE       = 8'h01;

    typedef enum logic
    {
        MODE_DATA = 1'b0,
        MODE_READ = 1'b1
    } mode_t;

    typedef enum logic
    {
        ST_BUILD = 1'b0,
        ST_RUN   = 1'b1
    } state_t;

    // Broadcast controls for the row of cells
    typedef struct packed
    {
        logic gen_clear;     // clear coefficients and parity (new count)
        logic gen_step;      // multiply generator by (x + root)
        logic absorb;        // LFSR step with feedback byte
        logic par_clear;     // clear parity after the last readout word
        logic shadow_load;   // copy parity into readout line
        logic shadow_shift;  // advance readout line
    } cell_ctrl_t;

    function automatic logic [BYTE_W-1:0] gf_xtime(input logic [BYTE_W-1:0] a);
        gf_xtime = {a[BYTE_W-2:0], 1'b0} ^ (a[BYTE_W-1] ? FIELD_POLY : '0);
    endfunction

    function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                 input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] p;
        p = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            p = gf_xtime(p) ^ (b[i] ? a : '0);
        end
        gf_mul = p;
    endfunction

    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
        if (v < MIN_PARITY)
        begin
            sat_count = MIN_PARITY;
        end
        else if (v > TOP_PARITY)
        begin
            sat_count = TOP_PARITY;
        end
        else
        begin
            sat_count = v;
        end
    endfunction

endpackage

`default_nettype wire

// File: design/reed_solomon_parity_encoder_core.sv
// Top level of the systematic Reed-Solomon parity encoder, GF(256), poly 0x11d.
// Depends on rspe_pkg, rspe_ctrl and rspe_cell.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------------------
//  cfg      | in        | cfg_valid / cfg_ready        | cfg_data[6:0]  parity_count
//  s_axis   | in        | s_axis_tvalid / s_axis_tready| tdata[7:0] data_byte, tuser mode
//  m_axis   | out       | m_axis_tvalid / m_axis_tready| tdata[7:0] parity_byte, tlast
//
// One word per cycle on s_axis (all 64 cells step at once); a readout result shows
// on m_axis the next cycle, and the output register refills as it empties.
// After reset and every cfg write the cell row builds the generator from n roots
// (16 after reset), one root per cycle, with both s_axis and cfg not ready.
// A stall on m_axis holds back every s_axis word while the output register is full;
// s_axis is also held in any cycle that offers a cfg write, which goes first.
//
// The row of cells holds, per position, the parity byte, a readout line byte and a
// generator coefficient (reversed order, so cell k meets g[n-1-k]). Positions at and
// beyond n keep zero coefficients and therefore stay zero.
`default_nettype none

module reed_solomon_parity_encoder_core
    import rspe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CNT_W-1:0]  cfg_data,       // parity_count
    // input words
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  wire logic              s_axis_tuser,   // [0] mode: 0 data, 1 readout
    // result words
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [BYTE_W-1:0] m_axis_tdata,   // [7:0] parity_byte
    output logic                   m_axis_tlast    // last_parity
);

    cell_ctrl_t        ctrl;
    logic [BYTE_W-1:0] fb;
    logic [BYTE_W-1:0] root;

    // chain taps: parity and readout run leftwards, coefficients rightwards
    logic [BYTE_W-1:0] par_w  [MAX_PARITY+1];
    logic [BYTE_W-1:0] sh_w   [MAX_PARITY+1];
    logic [BYTE_W-1:0] coef_w [MAX_PARITY+1];

    assign par_w[MAX_PARITY] = '0;
    assign sh_w[MAX_PARITY]  = '0;
    assign coef_w[0]         = GF_ONE;   // monic term of the reversed generator

    rspe_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (mode_t'(s_axis_tuser)),
        .in_byte   (s_axis_tdata),
        .par0      (par_w[0]),
        .sh0       (sh_w[0]),
        .ctrl      (ctrl),
        .fb        (fb),
        .root      (root),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    for (genvar k = 0; k < MAX_PARITY; k++)
    begin : g_cell
        rspe_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .fb        (fb),
            .root      (root),
            .par_right (par_w[k+1]),
            .sh_right  (sh_w[k+1]),
            .coef_left (coef_w[k]),
            .par       (par_w[k]),
            .sh        (sh_w[k]),
            .coef      (coef_w[k+1])
        );
    end

endmodule

`default_nettype wire

// File: design/rspe_cell.sv
// One cell of the parity row: parity byte, readout line byte, generator coefficient.
// Depends on rspe_pkg.
`default_nettype none

module rspe_cell
    import rspe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [BYTE_W-1:0] fb,         // feedback byte, broadcast
    input  wire logic [BYTE_W-1:0] root,       // current generator root, broadcast
    input  wire logic [BYTE_W-1:0] par_right,
    input  wire logic [BYTE_W-1:0] sh_right,
    input  wire logic [BYTE_W-1:0] coef_left,
    output logic      [BYTE_W-1:0] par,
    output logic      [BYTE_W-1:0] sh,
    output logic      [BYTE_W-1:0] coef
);

    logic [BYTE_W-1:0] par_reg, par_next;
    logic [BYTE_W-1:0] sh_reg, sh_next;
    logic [BYTE_W-1:0] coef_reg, coef_next;

    always_comb
    begin
        par_next  = par_reg;
        sh_next   = sh_reg;
        coef_next = coef_reg;
        if (ctrl.gen_clear || ctrl.par_clear)
        begin
            par_next = '0;
        end
        else if (ctrl.absorb)
        begin
            par_next = par_right ^ gf_mul(fb, coef_reg);
        end
        if (ctrl.shadow_load)
        begin
            sh_next = par_right;
        end
        else if (ctrl.shadow_shift)
        begin
            sh_next = sh_right;
        end
        if (ctrl.gen_clear)
        begin
            coef_next = '0;
        end
        else if (ctrl.gen_step)
        begin
            coef_next = coef_reg ^ gf_mul(root, coef_left);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_reg  <= '0;
            coef_reg <= '0;
        end
        else
        begin
            par_reg  <= par_next;
            coef_reg <= coef_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    assign par  = par_reg;
    assign sh   = sh_reg;
    assign coef = coef_reg;

endmodule

`default_nettype wire

// File: design/rspe_ctrl.sv
// Sequencer: generator build, handshakes, readout position and output register.
// Depends on rspe_pkg.
`default_nettype none

module rspe_ctrl
    import rspe_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CNT_W-1:0]  cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mode_t             in_mode,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic [BYTE_W-1:0] par0,      // parity byte of cell 0
    input  wire logic [BYTE_W-1:0] sh0,       // readout line byte of cell 0
    output cell_ctrl_t             ctrl,
    output logic      [BYTE_W-1:0] fb,
    output logic      [BYTE_W-1:0] root,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic      [BYTE_W-1:0] out_byte,
    output logic                   out_last
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [IDX_W-1:0]  step_reg, step_next;
    logic [BYTE_W-1:0] root_reg, root_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              ov_reg, ov_next;
    logic [BYTE_W-1:0] ob_reg, ob_next;
    logic              ol_reg, ol_next;

    logic cfg_acc, in_acc, is_last;

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        step_next  = step_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !out_ready;
        ob_next    = ob_reg;
        ol_next    = ol_reg;
        ctrl       = '0;

        cfg_ready = (state_reg == ST_RUN);
        // a pending cfg write goes first; input waits for that cycle
        in_ready  = (state_reg == ST_RUN) && !cfg_valid && (!ov_reg || out_ready);
        cfg_acc   = cfg_valid && cfg_ready;
        in_acc    = in_valid && in_ready;
        fb        = in_byte ^ par0;
        is_last   = (CNT_W'(cnt_reg) + CNT_W'(1)) == n_reg;

        case (state_reg)
            ST_BUILD:
            begin
                ctrl.gen_step = 1'b1;
                root_next     = gf_xtime(root_reg);
                step_next     = step_reg + IDX_W'(1);
                if (step_reg == IDX_W'(n_reg - CNT_W'(1)))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (cfg_acc)
                begin
                    ctrl.gen_clear = 1'b1;
                    n_next         = sat_count(cfg_data);
                    step_next      = '0;
                    root_next      = GF_ONE;
                    cnt_next       = '0;
                    state_next     = ST_BUILD;
                end
                else if (in_acc)
                begin
                    case (in_mode)
                        MODE_DATA:
                        begin
                            ctrl.absorb = 1'b1;
                            cnt_next    = '0;
                        end
                        MODE_READ:
                        begin
                            ov_next = 1'b1;
                            ob_next = (cnt_reg == '0) ? par0 : sh0;
                            ol_next = is_last;
                            if (cnt_reg == '0)
                            begin
                                ctrl.shadow_load = 1'b1;
                            end
                            else
                            begin
                                ctrl.shadow_shift = 1'b1;
                            end
                            if (is_last)
                            begin
                                ctrl.par_clear = 1'b1;
                                cnt_next       = '0;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + IDX_W'(1);
                            end
                        end
                        default:
                        begin
                            cnt_next = cnt_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BUILD;
            n_reg     <= RESET_PARITY;
            step_reg  <= '0;
            root_reg  <= GF_ONE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            step_reg  <= step_next;
            root_reg  <= root_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
        ol_reg <= ol_next;
    end

    assign root      = root_reg;
    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_last  = ol_reg;

endmodule

`default_nettype wire

// File: design/rspe_checker.sv
// Port-level checks for the parity encoder, bound to the top level.
// Depends on rspe_pkg and reed_solomon_parity_encoder_core.
`default_nettype none

module rspe_checker
    import rspe_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cfg_valid,
    input wire logic              cfg_ready,
    input wire logic              s_axis_tvalid,
    input wire logic              s_axis_tready,
    input wire logic              s_axis_tuser,
    input wire logic              m_axis_tvalid,
    input wire logic              m_axis_tready,
    input wire logic [BYTE_W-1:0] m_axis_tdata,
    input wire logic              m_axis_tlast
);

    logic s_acc, rd_acc;

    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign rd_acc = s_acc && (s_axis_tuser == MODE_READ);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // no input taken while a result is stuck in the output register
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tready)
        else $error("input ready while output register full and stalled");

    // every readout word gives a result in the next cycle
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        rd_acc |=> m_axis_tvalid)
        else $error("readout word produced no result");

    // a result only ever starts from a readout word
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(rd_acc))
        else $error("result appeared without readout word");

    // a count write starts a generator build: nothing taken next cycle
    a_cfg_build: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_axis_tready && !cfg_ready)
        else $error("block ready during generator build");

endmodule

bind reed_solomon_parity_encoder_core rspe_checker u_rspe_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
